// ===== sv/b64_pkg.sv =====
// Shared types, constants and character mapping functions for the Base64 codec.
// No dependencies.
package b64_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam int unsigned QDEPTH = 2;

  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;
  localparam logic [1:0] PH_3 = 2'd3;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // One accepted request's worth of results: cnt is result count minus one
  typedef struct packed {
    logic [1:0]      cnt;
    logic [3:0][7:0] data;
    logic            no_data;
    logic            last;
  } job_t;

  typedef struct packed {
    logic we;
    logic dir;
  } cfg_wr_t;

  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd63;
    if (c >= 8'h41 && c <= 8'h5A) d = c - 8'h41;
    else if (c >= 8'h61 && c <= 8'h7A) d = c - 8'h61 + 8'd26;
    else if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30 + 8'd52;
    else if (c == 8'h2B) d = 8'd62;
    return d[5:0];
  endfunction

  function automatic logic [7:0] char_of(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] r;
    w = {2'b00, v};
    if (w < 8'd26) r = w + 8'h41;
    else if (w < 8'd52) r = w - 8'd26 + 8'h61;
    else if (w < 8'd62) r = w - 8'd52 + 8'h30;
    else if (w == 8'd62) r = 8'h2B;
    else r = 8'h2F;
    return r;
  endfunction

endpackage

// ===== sv/b64_front.sv =====
// Front end: takes requests, holds group state and direction, and builds at most one
// job of up to four results per request. Depends on b64_pkg.
module b64_front (
  input  logic            clk,
  input  logic            rst,
  input  b64_pkg::cfg_wr_t cfg,
  output logic            direction,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      data_in,
  input  logic            last_in,
  output logic            job_valid,
  input  logic            job_ready,
  output b64_pkg::job_t   job
);
  import b64_pkg::*;

  logic [1:0] phase, phase_next;
  logic [5:0] carry, carry_next;
  logic       pad, pad_next;
  logic [5:0] v;
  logic       has;
  logic       accept;

  assign in_ready  = job_ready;
  assign accept    = in_valid && in_ready;
  assign job_valid = in_valid && has;

  always_comb begin
    v          = sextet_of(data_in);
    job.cnt    = 2'd0;
    job.data   = '0;
    job.no_data = 1'b0;
    job.last   = last_in;
    has        = 1'b0;
    phase_next = phase;
    carry_next = carry;
    pad_next   = pad;
    if (direction == DIR_ENCODE) begin
      has = 1'b1;
      unique case (phase)
        PH_1: begin
          job.data[0] = char_of(carry | {2'b00, data_in[7:4]});
          carry_next  = {data_in[3:0], 2'b00};
          phase_next  = PH_2;
          if (last_in) begin
            job.cnt     = 2'd2;
            job.data[1] = char_of(carry_next);
            job.data[2] = PAD_CHAR;
          end
        end
        PH_2: begin
          job.cnt     = 2'd1;
          job.data[0] = char_of(carry | {4'b0000, data_in[7:6]});
          job.data[1] = char_of(data_in[5:0]);
          carry_next  = '0;
          phase_next  = PH_0;
        end
        default: begin
          job.data[0] = char_of(data_in[7:2]);
          carry_next  = {data_in[1:0], 4'b0000};
          phase_next  = PH_1;
          if (last_in) begin
            job.cnt     = 2'd3;
            job.data[1] = char_of(carry_next);
            job.data[2] = PAD_CHAR;
            job.data[3] = PAD_CHAR;
          end
        end
      endcase
    end else if (!pad) begin
      unique case (phase)
        PH_0: begin
          carry_next = v;
          phase_next = PH_1;
        end
        PH_1: begin
          has         = 1'b1;
          job.data[0] = {carry, v[5:4]};
          carry_next  = {2'b00, v[3:0]};
          phase_next  = PH_2;
        end
        PH_2: begin
          if (data_in == PAD_CHAR) begin
            pad_next = 1'b1;
          end else begin
            has         = 1'b1;
            job.data[0] = {carry[3:0], v[5:2]};
            carry_next  = {4'b0000, v[1:0]};
            phase_next  = PH_3;
          end
        end
        PH_3: begin
          if (data_in == PAD_CHAR) begin
            pad_next = 1'b1;
          end else begin
            has         = 1'b1;
            job.data[0] = {carry[1:0], v};
            carry_next  = '0;
            phase_next  = PH_0;
          end
        end
      endcase
    end
    if (last_in) begin
      if (!has) begin
        has         = 1'b1;
        job.no_data = 1'b1;
      end
      phase_next = PH_0;
      carry_next = '0;
      pad_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
      phase     <= PH_0;
      carry     <= '0;
      pad       <= 1'b0;
    end else if (cfg.we) begin
      direction <= cfg.dir;
      phase     <= PH_0;
      carry     <= '0;
      pad       <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      carry <= carry_next;
      pad   <= pad_next;
    end
  end

endmodule

// ===== sv/b64_queue.sv =====
// Short job queue between front and back ends.
// Depends on b64_pkg.
module b64_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  b64_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output b64_pkg::job_t pop_data
);
  import b64_pkg::*;

  localparam int unsigned QW = $clog2(QDEPTH);

  job_t          mem [QDEPTH];
  logic [QW-1:0] wp, rp;
  logic [QW:0]   count;
  logic          push, pop;

  assign push_ready = count != QDEPTH[QW:0];
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/b64_back.sv =====
// Back end: holds the current job and sends its results one per cycle while out_ready is high.
// Depends on b64_pkg.
module b64_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  b64_pkg::job_t pop_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          no_data,
  output logic          out_last
);
  import b64_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       take, done;

  assign out_valid = cur_valid;
  assign out_byte  = cur.data[idx];
  assign no_data   = cur.no_data;
  assign out_last  = cur.last && (idx == cur.cnt);
  assign take      = out_valid && out_ready;
  assign done      = take && (idx == cur.cnt);
  assign pop_ready = !cur_valid || done;

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) cur <= pop_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop_ready) begin
      cur_valid <= pop_valid;
      idx       <= '0;
    end else if (take) begin
      idx <= idx + 1'b1;
    end
  end

endmodule

// ===== sv/base64_stream_codec_unit.sv =====
// Top level of the streaming Base64 codec: APB register port, front end, queue, back end.
// Depends on b64_pkg, b64_front, b64_queue, b64_back.
//
// Streaming Base64 codec (standard alphabet, '=' padding). Register 0 (byte address 0)
// holds direction: 0 encodes bytes to characters, 1 decodes characters to bytes; writing it
// aborts any partial message. A request is taken whenever the job queue has room; its
// zero to four results then leave the back end at one per cycle while out_ready is high,
// so the sustained rate is set by the output side. A final byte that starts a group
// yields four results. A final request that yields no data gives one result with no_data
// set. out_last marks the last result of each message.
module base64_stream_codec_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_in,
  input  logic        last_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        no_data,
  output logic        out_last
);
  import b64_pkg::*;

  cfg_wr_t cfg;
  logic    direction;
  logic    job_valid, job_ready;
  job_t    job;
  logic    pop_valid, pop_ready;
  job_t    pop_data;

  assign pready  = 1'b1;
  assign cfg.we  = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign cfg.dir = pwdata[0];
  assign prdata  = (paddr[2] == 1'b0) ? {31'b0, direction} : '0;

  b64_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .direction (direction),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_in   (data_in),
    .last_in   (last_in),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  b64_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (job_valid),
    .push_ready (job_ready),
    .push_data  (job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  b64_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .no_data   (no_data),
    .out_last  (out_last)
  );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for base64_stream_codec_unit: encode and decode requests are
// checked against an in-bench predictor under random idling, stalls and a long hold-off.
// Depends on b64_pkg and the codec RTL.
module tb_top;
  import b64_pkg::*;

  localparam logic [2:0] ADDR_DIRECTION = 3'd0;
  localparam logic [2:0] ADDR_SPARE = 3'd4;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 160;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] value;
    logic       marker;
    logic       tail;
  } codec_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_in = '0;
  logic        last_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        no_data;
  logic        out_last;

  // predictor state
  logic       codec_dir = DIR_ENCODE;
  logic [1:0] grp_phase = PH_0;
  logic [5:0] carry = '0;
  logic       pad_hit = 1'b0;

  codec_out_t pending_outputs[$];
  codec_out_t head;
  int mismatches = 0;
  int items_sent = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_request = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;

  base64_stream_codec_unit u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .data_in(data_in), .last_in(last_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .no_data(no_data), .out_last(out_last)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_request != hold_seen) begin
      hold_seen <= hold_request;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        note_mismatch($sformatf("unexpected output byte %02h no_data %0b last %0b",
                                out_byte, no_data, out_last));
      end else begin
        head = pending_outputs.pop_front();
        if (no_data !== head.marker || out_last !== head.tail ||
            (!head.marker && out_byte !== head.value))
          note_mismatch($sformatf("exp byte %02h no_data %0b last %0b, got %02h %0b %0b",
                                  head.value, head.marker, head.tail,
                                  out_byte, no_data, out_last));
      end
    end
  end

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    return ALPHABET[8*(63-int'(v)) +: 8];
  endfunction

  function automatic logic [5:0] char_sextet(input logic [7:0] c);
    logic [5:0] r;
    r = 6'd63;
    for (int i = 0; i < 64; i++)
      if (sextet_char(i[5:0]) == c) r = i[5:0];
    return r;
  endfunction

  task automatic await_output(input logic [7:0] v, input logic m);
    pending_outputs.push_back('{value: v, marker: m, tail: 1'b0});
  endtask

  task automatic predict_codec_output(input logic [7:0] d, input logic l);
    int start_count;
    logic [5:0] v;
    codec_out_t t;
    start_count = pending_outputs.size();
    if (codec_dir == DIR_ENCODE) begin
      case (grp_phase)
        PH_1: begin
          await_output(sextet_char(carry | {2'b00, d[7:4]}), 1'b0);
          carry = {d[3:0], 2'b00};
          grp_phase = PH_2;
          if (l) begin
            await_output(sextet_char(carry), 1'b0);
            await_output(PAD_CHAR, 1'b0);
          end
        end
        PH_2: begin
          await_output(sextet_char(carry | {4'b0000, d[7:6]}), 1'b0);
          await_output(sextet_char(d[5:0]), 1'b0);
          carry = '0;
          grp_phase = PH_0;
        end
        default: begin
          await_output(sextet_char(d[7:2]), 1'b0);
          carry = {d[1:0], 4'b0000};
          grp_phase = PH_1;
          if (l) begin
            await_output(sextet_char(carry), 1'b0);
            await_output(PAD_CHAR, 1'b0);
            await_output(PAD_CHAR, 1'b0);
          end
        end
      endcase
    end else if (!pad_hit) begin
      v = char_sextet(d);
      case (grp_phase)
        PH_0: begin
          carry = v;
          grp_phase = PH_1;
        end
        PH_1: begin
          await_output({carry, v[5:4]}, 1'b0);
          carry = {2'b00, v[3:0]};
          grp_phase = PH_2;
        end
        PH_2: begin
          if (d == PAD_CHAR) pad_hit = 1'b1;
          else begin
            await_output({carry[3:0], v[5:2]}, 1'b0);
            carry = {4'b0000, v[1:0]};
            grp_phase = PH_3;
          end
        end
        default: begin
          if (d == PAD_CHAR) pad_hit = 1'b1;
          else begin
            await_output({carry[1:0], v}, 1'b0);
            carry = '0;
            grp_phase = PH_0;
          end
        end
      endcase
    end
    if (l) begin
      if (pending_outputs.size() == start_count) await_output(8'h00, 1'b1);
      t = pending_outputs.pop_back();
      t.tail = 1'b1;
      pending_outputs.push_back(t);
      grp_phase = PH_0;
      carry = '0;
      pad_hit = 1'b0;
    end
  endtask

  task automatic send_item(input logic [7:0] d, input logic l);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_in <= d;
    last_in <= l;
    do @(posedge clk); while (!in_ready);
    predict_codec_output(d, l);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves the bus in the access phase; a readback always follows
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_DIRECTION) begin
      codec_dir = val[0];
      grp_phase = PH_0;
      carry = '0;
      pad_hit = 1'b0;
    end
  endtask

  task automatic check_direction_readback();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_DIRECTION;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'b0, codec_dir})
      note_mismatch($sformatf("direction readback exp %0b got %08h", codec_dir, prdata));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_direction(input logic d);
    wait_idle();
    write_reg(ADDR_DIRECTION, {31'b0, d});
    check_direction_readback();
  endtask

  task automatic send_encode_message();
    int nbytes;
    logic [7:0] b;
    nbytes = $urandom_range(9, 1);
    for (int i = 0; i < nbytes; i++) begin
      case ($urandom_range(9))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom_range(255));
      endcase
      send_item(b, i == nbytes - 1);
    end
  endtask

  // well-formed text with padding, or noise / trailing junk when broken
  task automatic send_decode_message(input bit broken);
    int nchars, npad, extra, total;
    logic [7:0] c;
    nchars = $urandom_range(12, 1);
    npad = (nchars % 4 == 2) ? 2 : (nchars % 4 == 3) ? 1 : 0;
    extra = 0;
    if (broken) begin
      npad = $urandom_range(2);
      extra = $urandom_range(3);
    end
    total = nchars + npad + extra;
    for (int i = 0; i < total; i++) begin
      if (i < nchars)
        c = (broken && $urandom_range(99) < 25) ? 8'($urandom_range(255))
                                                : sextet_char(6'($urandom_range(63)));
      else if (i < nchars + npad) c = PAD_CHAR;
      else c = 8'($urandom_range(255));
      send_item(c, i == total - 1);
    end
  endtask

  task automatic test_encode_basics();
    set_direction(DIR_ENCODE);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item("M", 1'b0);
    send_item("a", 1'b0);
    send_item("n", 1'b1);
    // partial group dropped by a direction write
    send_item("A", 1'b0);
    set_direction(DIR_ENCODE);
    send_item(8'hFF, 1'b1);
  endtask

  task automatic test_decode_basics();
    set_direction(DIR_DECODE);
    send_item("a", 1'b0);
    send_item("z", 1'b0);
    send_item("+", 1'b0);
    send_item("/", 1'b1);
    send_item("T", 1'b0);
    send_item("Q", 1'b0);
    send_item(PAD_CHAR, 1'b0);
    send_item(PAD_CHAR, 1'b1);
    send_item("0", 1'b0);
    send_item("9", 1'b0);
    send_item("Z", 1'b0);
    send_item(PAD_CHAR, 1'b1);
    // pad in the first position and non-alphabet bytes
    send_item(PAD_CHAR, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item("A", 1'b1);
  endtask

  task automatic test_register_access();
    set_direction(DIR_DECODE);
    send_item("T", 1'b0);
    wait_idle();
    write_reg(ADDR_SPARE, 32'h0);
    check_direction_readback();
    send_item("Q", 1'b1);
  endtask

  task automatic test_backpressure();
    set_direction(DIR_ENCODE);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_request <= hold_request + 1;
    repeat (8) begin
      send_item(8'($urandom_range(255)), 1'b0);
      send_item(8'($urandom_range(255)), 1'b0);
      send_item(8'($urandom_range(255)), 1'b1);
    end
    wait_drained();
    send_encode_message();
    send_encode_message();
  endtask

  task automatic run_traffic_phase(input int idle, input int stall, input int nitems);
    int stop_at;
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    stop_at = items_sent + nitems;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 20) set_direction(1'($urandom_range(1)));
      if (codec_dir == DIR_DECODE) send_decode_message($urandom_range(99) < 25);
      else send_encode_message();
    end
  endtask

  task automatic test_random_traffic();
    set_direction(DIR_DECODE);
    run_traffic_phase(0, 0, 50);
    set_direction(DIR_ENCODE);
    run_traffic_phase(87, 0, 50);
    set_direction(DIR_DECODE);
    run_traffic_phase(0, 87, 50);
    set_direction(DIR_ENCODE);
    run_traffic_phase(20, 20, 50);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_encode_basics();
    test_decode_basics();
    test_register_access();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_outputs.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
